// ----- sv/gdc_pkg.sv -----
`timescale 1ns / 1ps

package gdc_pkg;

   // Calendar constants
   localparam int unsigned MaxYear    = 9999;
   localparam int unsigned DaysPer400 = 146097;
   localparam int unsigned DaysPer100 = 36524;
   localparam int unsigned DaysPer4   = 1461;
   localparam int unsigned DaysPer1   = 365;
   localparam int unsigned CountLimit = 4194303;

   // Last accepted day count: 31 December of the last supported year
   localparam int unsigned LastFull   = (MaxYear + 1) * DaysPer1 + MaxYear / 4
                                        - MaxYear / 100 + MaxYear / 400;
   localparam int unsigned LastCount  = (LastFull > CountLimit) ? CountLimit : LastFull;

   // Reciprocal multipliers; floor-based ones undershoot by at most one
   localparam int unsigned Div400Shift  = 22;
   localparam int unsigned Div400Mul    = (2 ** Div400Shift) / DaysPer400;
   localparam int unsigned Div7Shift    = 23;
   localparam int unsigned Div7Mul      = (2 ** Div7Shift) / 7;
   localparam int unsigned Div1461Shift = 16;
   localparam int unsigned Div1461Mul   = (2 ** Div1461Shift) / DaysPer4;
   // Rounded-up reciprocal, exact for operands below 43690
   localparam int unsigned Div25Shift   = 20;
   localparam int unsigned Div25Mul     = (2 ** Div25Shift + 24) / 25;

   typedef struct packed {
      logic        command;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [21:0] day_count;
   } gdc_req_type;

   typedef struct packed {
      logic        valid_res;
      logic [21:0] count_out;
      logic [13:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [2:0]  weekday;
      logic [4:0]  month_length;
   } gdc_rsp_type;

   // Day of year on which a month begins, zero based
   function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
      logic [8:0] base;
      unique case (month)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && month >= 4'd3 && month <= 4'd12) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

   // Days in a month, zero for a month code outside January to December
   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ----- sv/gregorian_date_daycount_converter_unit.sv -----
// From the accepting edge, a request passes through eleven register stages, the first
// loaded at the accepting edge and the last being the output register.
// Throughput: one transaction per cycle unless stalled; every stage has its own valid bit.
// All stages advance together and hold while a stalled response sits in the output register.
// Reset (synchronous, active high) clears the valid bits only; data registers are not reset.
`timescale 1ns / 1ps

module gregorian_date_daycount_converter_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gdc_pkg::gdc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output gdc_pkg::gdc_rsp_type rsp_data
);
   import gdc_pkg::*;

   localparam int unsigned Stages = 11;

   // Fields that ride unchanged from the date lane and the weekday lane to the output
   typedef struct packed {
      logic        cmd;
      logic        c0_valid;
      logic [21:0] c0_count;
      logic [4:0]  c0_len;
      logic        in_range;
      logic [2:0]  wday;
   } hold_type;

   typedef struct packed {
      logic        cmd;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [7:0]  q25;
      logic [21:0] n;
      logic [4:0]  q400_est;
      logic [22:0] wx;
      logic        in_range;
   } st1_type;

   typedef struct packed {
      logic        cmd;
      logic [13:0] year;
      logic [11:0] quarter;
      logic [7:0]  q100;
      logic [9:0]  offs;
      logic [4:0]  len;
      logic        date_ok;
      logic [4:0]  q400_est;
      logic [18:0] r400;
      logic [22:0] wx;
      logic [19:0] w7_est;
      logic        in_range;
   } st2_type;

   typedef struct packed {
      logic        cmd;
      logic [22:0] ys;
      logic [9:0]  offs;
      logic [4:0]  len;
      logic        date_ok;
      logic [4:0]  q400;
      logic [17:0] r400;
      logic [3:0]  w4;
      logic        in_range;
   } st3_type;

   typedef struct packed {
      hold_type    hold;
      logic [4:0]  q400;
      logic [1:0]  cent;
      logic        later_cent;
      logic [15:0] rem;
   } st4_type;

   typedef struct packed {
      hold_type    hold;
      logic [4:0]  q400;
      logic [1:0]  cent;
      logic [2:0]  y5;
      logic        head_plain;
      logic [15:0] rem;
   } st5_type;

   typedef struct packed {
      hold_type    hold;
      logic [4:0]  q400;
      logic [1:0]  cent;
      logic [2:0]  y5;
      logic        head_plain;
      logic [4:0]  q1461_est;
      logic [15:0] rem;
   } st6_type;

   typedef struct packed {
      hold_type    hold;
      logic [4:0]  q400;
      logic [1:0]  cent;
      logic [2:0]  y5;
      logic        head_plain;
      logic [4:0]  q1461_est;
      logic [11:0] rem;
   } st7_type;

   typedef struct packed {
      hold_type    hold;
      logic [4:0]  q400;
      logic [1:0]  cent;
      logic [2:0]  y5;
      logic        head_plain;
      logic [4:0]  q1461;
      logic [10:0] rem;
   } st8_type;

   typedef struct packed {
      hold_type    hold;
      logic [4:0]  q400;
      logic [1:0]  cent;
      logic [2:0]  y5;
      logic [4:0]  q1461;
      logic [1:0]  q1;
      logic        leap;
      logic [8:0]  rem;
   } st9_type;

   typedef struct packed {
      hold_type    hold;
      logic [13:0] year;
      logic [3:0]  month;
      logic        leap;
      logic [8:0]  rem;
   } st10_type;

   logic               adv;
   logic [Stages:1]    vld_ff, vld_in;
   st1_type            st1_ff, st1_in;
   st2_type            st2_ff, st2_in;
   st3_type            st3_ff, st3_in;
   st4_type            st4_ff, st4_in;
   st5_type            st5_ff, st5_in;
   st6_type            st6_ff, st6_in;
   st7_type            st7_ff, st7_in;
   st8_type            st8_ff, st8_in;
   st9_type            st9_ff, st9_in;
   st10_type           st10_ff, st10_in;
   gdc_rsp_type        rsp_ff, rsp_in;

   // Advance the whole pipe unless the output holds a stalled response
   assign adv       = !vld_ff[Stages] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[Stages];
   assign rsp_data  = rsp_ff;
   assign vld_in    = {vld_ff[Stages-1:1], req_valid};

   // Stage 1: year/100 estimate, 400-year estimate, weekday offset, range check
   always_comb begin
      logic [27:0] q25_prod;
      logic [26:0] q400_prod;
      q25_prod  = 28'(req_data.year[13:2]) * 28'(Div25Mul);
      q400_prod = 27'(req_data.day_count) * 27'(Div400Mul);
      st1_in.cmd      = req_data.command;
      st1_in.year     = req_data.year;
      st1_in.month    = req_data.month;
      st1_in.day      = req_data.day;
      st1_in.q25      = 8'(q25_prod >> Div25Shift);
      st1_in.n        = req_data.day_count;
      st1_in.q400_est = 5'(q400_prod >> Div400Shift);
      st1_in.wx       = 23'(req_data.day_count) + 23'd6;
      st1_in.in_range = req_data.day_count <= 22'(LastCount);
   end

   // Stage 2: leap rule, month length, offset and date check; 400-year remainder; weekday estimate
   always_comb begin
      logic [11:0] yq;
      logic        y4;
      logic        is25;
      logic        leap;
      logic [4:0]  len;
      logic [21:0] r_full;
      logic [42:0] w7_prod;
      yq      = st1_ff.year[13:2];
      y4      = st1_ff.year[1:0] == 2'd0;
      is25    = (13'(st1_ff.q25) * 13'd25) == 13'(yq);
      leap    = y4 && (!is25 || st1_ff.year[3:2] == 2'd0);
      len     = month_days(st1_ff.month, leap);
      r_full  = st1_ff.n - 22'(st1_ff.q400_est) * 22'(DaysPer400);
      w7_prod = 43'(st1_ff.wx) * 43'(Div7Mul);
      st2_in.cmd      = st1_ff.cmd;
      st2_in.year     = st1_ff.year;
      // p = year - 1: p/4 and p/100 drop by one on a multiple of four or of a hundred
      st2_in.quarter  = yq - 12'(y4 && yq != 12'd0);
      st2_in.q100     = st1_ff.q25 - 8'(y4 && is25 && yq != 12'd0);
      st2_in.offs     = 10'(month_start(st1_ff.month, leap)) + 10'(st1_ff.day);
      st2_in.len      = len;
      st2_in.date_ok  = st1_ff.year <= 14'(MaxYear) && len != 5'd0 &&
                        st1_ff.day != 5'd0 && st1_ff.day <= len;
      st2_in.q400_est = st1_ff.q400_est;
      st2_in.r400     = r_full[18:0];
      st2_in.wx       = st1_ff.wx;
      st2_in.w7_est   = 20'(w7_prod >> Div7Shift);
      st2_in.in_range = st1_ff.in_range;
   end

   // Stage 3: start of year; correct the 400-year quotient; weekday remainder
   always_comb begin
      logic [22:0] wrem;
      wrem = st2_ff.wx - 23'(st2_ff.w7_est) * 23'd7;
      st3_in.cmd = st2_ff.cmd;
      if (st2_ff.year == 14'd0) begin
         st3_in.ys = 23'd0;
      end else begin
         st3_in.ys = 23'(st2_ff.year) * 23'(DaysPer1) + 23'd1 + 23'(st2_ff.quarter)
                     - 23'(st2_ff.q100) + 23'(st2_ff.q100[7:2]);
      end
      st3_in.offs    = st2_ff.offs;
      st3_in.len     = st2_ff.len;
      st3_in.date_ok = st2_ff.date_ok;
      if (st2_ff.r400 >= 19'(DaysPer400)) begin
         st3_in.q400 = st2_ff.q400_est + 5'd1;
         st3_in.r400 = 18'(st2_ff.r400 - 19'(DaysPer400));
      end else begin
         st3_in.q400 = st2_ff.q400_est;
         st3_in.r400 = 18'(st2_ff.r400);
      end
      st3_in.w4       = wrem[3:0];
      st3_in.in_range = st2_ff.in_range;
   end

   // Stage 4: finish the day count; split off centuries; finish the weekday
   always_comb begin
      logic [22:0] c;
      logic [17:0] rc;
      logic [1:0]  cent;
      logic [17:0] remc;
      c  = st3_ff.ys + 23'(st3_ff.offs) - 23'd1;
      rc = st3_ff.r400 - 18'd1;
      priority if (rc >= 18'(3 * DaysPer100)) begin
         cent = 2'd3;
      end else if (rc >= 18'(2 * DaysPer100)) begin
         cent = 2'd2;
      end else begin
         cent = 2'd1;
      end
      remc = rc - 18'(cent) * 18'(DaysPer100);
      st4_in.hold.cmd      = st3_ff.cmd;
      st4_in.hold.c0_valid = st3_ff.date_ok && !c[22];
      st4_in.hold.c0_count = c[21:0];
      st4_in.hold.c0_len   = st3_ff.len;
      st4_in.hold.in_range = st3_ff.in_range;
      st4_in.hold.wday     = (st3_ff.w4 >= 4'd7) ? 3'(st3_ff.w4 - 4'd7) : 3'(st3_ff.w4);
      st4_in.q400          = st3_ff.q400;
      // The first century of each 400-year cycle keeps its leap day at the start
      st4_in.later_cent    = st3_ff.r400 >= 18'(DaysPer100 + 1);
      st4_in.cent          = st4_in.later_cent ? cent : 2'd0;
      st4_in.rem           = st4_in.later_cent ? 16'(remc) : 16'(st3_ff.r400);
   end

   // Stage 5: the first four years of a later century have no leap day
   always_comb begin
      logic [2:0] y5;
      y5 = 3'd0;
      st5_in.head_plain = 1'b0;
      st5_in.rem        = st4_ff.rem;
      if (st4_ff.later_cent) begin
         if (st4_ff.rem >= 16'(4 * DaysPer1)) begin
            y5         = 3'd4;
            st5_in.rem = st4_ff.rem - 16'(4 * DaysPer1);
         end else begin
            st5_in.head_plain = 1'b1;
            priority if (st4_ff.rem >= 16'(3 * DaysPer1)) begin
               y5 = 3'd3;
            end else if (st4_ff.rem >= 16'(2 * DaysPer1)) begin
               y5 = 3'd2;
            end else if (st4_ff.rem >= 16'(DaysPer1)) begin
               y5 = 3'd1;
            end else begin
               y5 = 3'd0;
            end
            st5_in.rem = st4_ff.rem - 16'(y5) * 16'(DaysPer1);
         end
      end
      st5_in.hold = st4_ff.hold;
      st5_in.q400 = st4_ff.q400;
      st5_in.cent = st4_ff.cent;
      st5_in.y5   = y5;
   end

   // Stage 6: estimate the count of four-year blocks
   always_comb begin
      logic [21:0] q_prod;
      q_prod = 22'(st5_ff.rem) * 22'(Div1461Mul);
      st6_in.hold       = st5_ff.hold;
      st6_in.q400       = st5_ff.q400;
      st6_in.cent       = st5_ff.cent;
      st6_in.y5         = st5_ff.y5;
      st6_in.head_plain = st5_ff.head_plain;
      st6_in.q1461_est  = 5'(q_prod >> Div1461Shift);
      st6_in.rem        = st5_ff.rem;
   end

   // Stage 7: remainder after the estimated four-year blocks
   always_comb begin
      logic [15:0] r_full;
      r_full = st6_ff.rem - 16'(st6_ff.q1461_est) * 16'(DaysPer4);
      st7_in.hold       = st6_ff.hold;
      st7_in.q400       = st6_ff.q400;
      st7_in.cent       = st6_ff.cent;
      st7_in.y5         = st6_ff.y5;
      st7_in.head_plain = st6_ff.head_plain;
      st7_in.q1461_est  = st6_ff.q1461_est;
      st7_in.rem        = r_full[11:0];
   end

   // Stage 8: correct the four-year quotient
   always_comb begin
      st8_in.hold       = st7_ff.hold;
      st8_in.q400       = st7_ff.q400;
      st8_in.cent       = st7_ff.cent;
      st8_in.y5         = st7_ff.y5;
      st8_in.head_plain = st7_ff.head_plain;
      if (st7_ff.rem >= 12'(DaysPer4)) begin
         st8_in.q1461 = st7_ff.q1461_est + 5'd1;
         st8_in.rem   = 11'(st7_ff.rem - 12'(DaysPer4));
      end else begin
         st8_in.q1461 = st7_ff.q1461_est;
         st8_in.rem   = 11'(st7_ff.rem);
      end
   end

   // Stage 9: year within the four-year block; the leap year leads the block
   always_comb begin
      logic        tail_step;
      logic [10:0] rc;
      logic [1:0]  q1;
      logic [10:0] rem_t;
      tail_step = st8_ff.rem >= 11'(DaysPer1 + 1);
      rc        = st8_ff.rem - 11'd1;
      priority if (rc >= 11'(3 * DaysPer1)) begin
         q1 = 2'd3;
      end else if (rc >= 11'(2 * DaysPer1)) begin
         q1 = 2'd2;
      end else begin
         q1 = 2'd1;
      end
      rem_t = rc - 11'(q1) * 11'(DaysPer1);
      st9_in.hold  = st8_ff.hold;
      st9_in.q400  = st8_ff.q400;
      st9_in.cent  = st8_ff.cent;
      st9_in.y5    = st8_ff.y5;
      st9_in.q1461 = st8_ff.q1461;
      st9_in.q1    = tail_step ? q1 : 2'd0;
      st9_in.leap  = !tail_step && !st8_ff.head_plain;
      st9_in.rem   = tail_step ? rem_t[8:0] : st8_ff.rem[8:0];
   end

   // Stage 10: assemble the year; search the month
   always_comb begin
      logic [3:0] month;
      month = 4'd1;
      for (int i = 2; i <= 12; i++) begin
         if (st9_ff.rem >= month_start(4'(i), st9_ff.leap)) begin
            month = 4'(i);
         end
      end
      st10_in.hold  = st9_ff.hold;
      st10_in.year  = 14'(st9_ff.q400) * 14'd400 + 14'(st9_ff.cent) * 14'd100
                      + 14'(st9_ff.y5) + 14'(st9_ff.q1461) * 14'd4 + 14'(st9_ff.q1);
      st10_in.month = month;
      st10_in.leap  = st9_ff.leap;
      st10_in.rem   = st9_ff.rem;
   end

   // Stage 11: day of month; drop the fields the command does not produce
   always_comb begin
      logic [8:0] day_full;
      day_full = st10_ff.rem + 9'd1 - month_start(st10_ff.month, st10_ff.leap);
      rsp_in = '0;
      if (!st10_ff.hold.cmd) begin
         rsp_in.valid_res    = st10_ff.hold.c0_valid;
         rsp_in.count_out    = st10_ff.hold.c0_valid ? st10_ff.hold.c0_count : 22'd0;
         rsp_in.month_length = st10_ff.hold.c0_len;
      end else if (st10_ff.hold.in_range) begin
         rsp_in.valid_res = 1'b1;
         rsp_in.year_out  = st10_ff.year;
         rsp_in.month_out = st10_ff.month;
         rsp_in.day_out   = day_full[4:0];
         rsp_in.weekday   = st10_ff.hold.wday;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Advance data; hold on stall
   always_ff @(posedge clock) begin
      if (adv) begin
         st1_ff  <= st1_in;
         st2_ff  <= st2_in;
         st3_ff  <= st3_in;
         st4_ff  <= st4_in;
         st5_ff  <= st5_in;
         st6_ff  <= st6_in;
         st7_ff  <= st7_in;
         st8_ff  <= st8_in;
         st9_ff  <= st9_in;
         st10_ff <= st10_in;
         rsp_ff  <= rsp_in;
      end
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import gdc_pkg::*;

   typedef int unsigned uint_type;

   // Command codes carried in the request's command bit
   typedef enum logic {
      CmdToCount = 1'b0,
      CmdToDate  = 1'b1
   } conv_cmd_type;

   // Patterns the response side cycles through
   typedef enum int unsigned {
      StallNone,
      StallLight,
      StallHeavy,
      StallPeriodic
   } stall_kind_type;

   typedef struct {
      gdc_req_type req;
      bit          pinned;
      gdc_rsp_type rsp;
   } stim_row_type;

   localparam uint_type WidestCount = 4194303;
   localparam uint_type PipeDepth   = 11;
   localparam uint_type IdleLimit   = 5000;
   localparam uint_type RandomItems = 1950;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   gdc_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   gdc_rsp_type rsp_data;

   // Fixed expectation travelling with the request currently driven
   bit          row_pinned = 1'b0;
   gdc_rsp_type row_rsp    = '0;

   gdc_rsp_type      outstanding_rsps[$];
   stim_row_type     directed_rows[$];
   uint_type         mismatches  = 0;
   uint_type         idle_cycles = 0;
   uint_type         burst_left  = 0;
   uint_type         stall_left  = 0;
   stall_kind_type   stall_kind  = StallNone;

   always #5 clock = ~clock;

   gregorian_date_daycount_converter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Calendar arithmetic
   function automatic bit is_leap(uint_type y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   function automatic uint_type days_in_month(uint_type m, bit leap);
      case (m)
         2:                       return leap ? 29 : 28;
         4, 6, 9, 11:             return 30;
         1, 3, 5, 7, 8, 10, 12:   return 31;
         default:                 return 0;
      endcase
   endfunction

   // Day count of 1 January of year y
   function automatic uint_type year_first_day(uint_type y);
      uint_type p;
      if (y == 0) return 0;
      p = y - 1;
      return y * 365 + 1 + p / 4 - p / 100 + p / 400;
   endfunction

   function automatic uint_type last_valid_count();
      uint_type last;
      last = year_first_day(MaxYear + 1) - 1;
      return (last > WidestCount) ? WidestCount : last;
   endfunction

   // Expected response for one request
   function automatic gdc_rsp_type convert_calendar(gdc_req_type r);
      gdc_rsp_type res;
      bit          leap;
      uint_type    y, m, mon, dy, len, cnt, rem, n;
      res = '0;
      if (r.command == CmdToCount) begin
         y    = uint_type'(r.year);
         mon  = uint_type'(r.month);
         dy   = uint_type'(r.day);
         leap = is_leap(y);
         len  = days_in_month(mon, leap);
         res.month_length = 5'(len);
         if (y <= MaxYear && len != 0 && dy >= 1 && dy <= len) begin
            cnt = year_first_day(y) + dy - 1;
            for (m = 1; m < mon; m++) begin
               cnt += days_in_month(m, leap);
            end
            if (cnt <= WidestCount) begin
               res.valid_res = 1'b1;
               res.count_out = 22'(cnt);
            end
         end
      end else begin
         n = uint_type'(r.day_count);
         if (n <= last_valid_count()) begin
            // estimate the year, then walk onto it
            y = n * 400 / 146097;
            while (year_first_day(y + 1) <= n) y++;
            while (year_first_day(y) > n) y--;
            rem  = n - year_first_day(y);
            leap = is_leap(y);
            m    = 1;
            while (rem >= days_in_month(m, leap)) begin
               rem -= days_in_month(m, leap);
               m++;
            end
            res.valid_res = 1'b1;
            res.year_out  = 14'(y);
            res.month_out = 4'(m);
            res.day_out   = 5'(rem + 1);
            res.weekday   = 3'((n + 6) % 7);
         end
      end
      return res;
   endfunction

   function automatic gdc_req_type make_req(conv_cmd_type cmd, uint_type y, uint_type m,
                                            uint_type d, uint_type n);
      gdc_req_type r;
      r.command   = cmd;
      r.year      = 14'(y);
      r.month     = 4'(m);
      r.day       = 5'(d);
      r.day_count = 22'(n);
      return r;
   endfunction

   function automatic gdc_rsp_type make_rsp(bit v, uint_type cnt, uint_type y, uint_type m,
                                            uint_type d, uint_type wd, uint_type len);
      gdc_rsp_type e;
      e.valid_res    = v;
      e.count_out    = 22'(cnt);
      e.year_out     = 14'(y);
      e.month_out    = 4'(m);
      e.day_out      = 5'(d);
      e.weekday      = 3'(wd);
      e.month_length = 5'(len);
      return e;
   endfunction

   task automatic add_row(gdc_req_type r, bit pin, gdc_rsp_type e);
      stim_row_type row;
      row.req    = r;
      row.pinned = pin;
      row.rsp    = e;
      directed_rows.push_back(row);
   endtask

   // Random request, mostly well-formed dates and in-range counts
   function automatic gdc_req_type draw_item();
      gdc_req_type r;
      uint_type    kind, y, m, len, last;
      r.command   = 1'($urandom);
      r.year      = 14'($urandom);
      r.month     = 4'($urandom);
      r.day       = 5'($urandom);
      r.day_count = 22'($urandom);
      last        = last_valid_count();
      kind        = $urandom_range(0, 99);
      if (kind < 45) begin
         r.command = CmdToCount;
         if ($urandom_range(0, 3) == 0) begin
            y = 100 * $urandom_range(0, MaxYear / 100) + $urandom_range(0, 4);
            if (y > MaxYear) y = MaxYear;
         end else begin
            y = $urandom_range(0, MaxYear);
         end
         m   = $urandom_range(1, 12);
         len = days_in_month(m, is_leap(y));
         r.year  = 14'(y);
         r.month = 4'(m);
         r.day   = 5'($urandom_range(1, len));
      end else if (kind < 80) begin
         r.command   = CmdToDate;
         r.day_count = 22'($urandom_range(0, last));
      end else if (kind < 88) begin
         // near-valid date with a loose day and year
         r.command = CmdToCount;
         r.year    = 14'($urandom_range(0, MaxYear + 20));
         r.month   = 4'($urandom_range(1, 12));
      end else if (kind < 92) begin
         r.command   = CmdToDate;
         r.day_count = 22'(last - 3 + $urandom_range(0, 6));
      end
      return r;
   endfunction

   task automatic check_field(string name, uint_type want, uint_type got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Score responses, record accepted requests, run the watchdog
   always @(posedge clock) begin : scoreboard
      gdc_rsp_type want;
      bit          moved;
      moved = 1'b0;
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         moved = 1'b1;
         if (outstanding_rsps.size() == 0) begin
            $display("%0t: unexpected transaction, expected none actual %p", $time, rsp_data);
            mismatches++;
         end else begin
            want = outstanding_rsps.pop_front();
            check_field("valid_res", uint_type'(want.valid_res),
                        uint_type'(rsp_data.valid_res));
            check_field("count_out", uint_type'(want.count_out),
                        uint_type'(rsp_data.count_out));
            check_field("year_out", uint_type'(want.year_out), uint_type'(rsp_data.year_out));
            check_field("month_out", uint_type'(want.month_out),
                        uint_type'(rsp_data.month_out));
            check_field("day_out", uint_type'(want.day_out), uint_type'(rsp_data.day_out));
            check_field("weekday", uint_type'(want.weekday), uint_type'(rsp_data.weekday));
            check_field("month_length", uint_type'(want.month_length),
                        uint_type'(rsp_data.month_length));
         end
      end
      if (req_valid && req_stall === 1'b0) begin
         moved = 1'b1;
         outstanding_rsps.push_back(row_pinned ? row_rsp : convert_calendar(req_data));
      end
      // count cycles with no transaction on either side
      if (moved) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // Response stall: switch among patterns every stretch of cycles
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_kind = stall_kind_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 160);
      end else begin
         stall_left--;
      end
      case (stall_kind)
         StallNone:  rsp_stall <= 1'b0;
         StallLight: rsp_stall <= ($urandom_range(0, 3) == 0);
         StallHeavy: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:    rsp_stall <= ((stall_left % 5) < 2);
      endcase
   end

   // Drive one request and hold it until accepted
   task automatic send_item(gdc_req_type r, bit pin, gdc_rsp_type e);
      req_data   <= r;
      row_pinned <= pin;
      row_rsp    <= e;
      req_valid  <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Bursts of random length with random gaps between them
   task automatic pace_sender();
      uint_type gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 32);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Hold off until every outstanding transaction has returned
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding_rsps.size() != 0);
   endtask

   initial begin : stimulus
      gdc_rsp_type none;
      none = '0;

      // extremes, leap rules and out-of-range cases
      add_row(make_req(CmdToCount, 0, 1, 1, 0), 1, make_rsp(1, 0, 0, 0, 0, 0, 31));
      add_row(make_req(CmdToDate, 0, 0, 0, 0), 1, make_rsp(1, 0, 0, 1, 1, 6, 0));
      add_row(make_req(CmdToCount, 0, 2, 29, 0), 1, make_rsp(1, 59, 0, 0, 0, 0, 29));
      add_row(make_req(CmdToDate, 0, 0, 0, 59), 1, make_rsp(1, 0, 0, 2, 29, 2, 0));
      add_row(make_req(CmdToDate, 0, 0, 0, 366), 1, make_rsp(1, 0, 1, 1, 1, 1, 0));
      add_row(make_req(CmdToCount, 9999, 12, 31, 0), 1,
              make_rsp(1, 3652424, 0, 0, 0, 0, 31));
      add_row(make_req(CmdToDate, 0, 0, 0, 3652424), 1,
              make_rsp(1, 0, 9999, 12, 31, 5, 0));
      add_row(make_req(CmdToDate, 0, 0, 0, 3652425), 1, none);
      add_row(make_req(CmdToDate, 16383, 15, 31, 4194303), 1, none);
      add_row(make_req(CmdToCount, 10000, 1, 1, 0), 1, make_rsp(0, 0, 0, 0, 0, 0, 31));
      add_row(make_req(CmdToCount, 16383, 2, 1, 0), 1, make_rsp(0, 0, 0, 0, 0, 0, 28));
      add_row(make_req(CmdToCount, 2000, 0, 1, 0), 1, none);
      add_row(make_req(CmdToCount, 2000, 15, 1, 0), 1, none);
      add_row(make_req(CmdToCount, 2000, 1, 0, 0), 1, make_rsp(0, 0, 0, 0, 0, 0, 31));
      add_row(make_req(CmdToCount, 2000, 2, 30, 0), 1, make_rsp(0, 0, 0, 0, 0, 0, 29));
      add_row(make_req(CmdToCount, 1900, 2, 29, 0), 1, make_rsp(0, 0, 0, 0, 0, 0, 28));
      add_row(make_req(CmdToCount, 16383, 15, 31, 4194303), 1, none);
      add_row(make_req(CmdToCount, 1, 1, 1, 4194303), 1, make_rsp(1, 366, 0, 0, 0, 0, 31));
      // century and cycle boundaries
      add_row(make_req(CmdToCount, 2000, 2, 29, 0), 0, none);
      add_row(make_req(CmdToCount, 2100, 3, 1, 0), 0, none);
      add_row(make_req(CmdToDate, 0, 0, 0, 146096), 0, none);
      add_row(make_req(CmdToDate, 0, 0, 0, 146097), 0, none);
      add_row(make_req(CmdToDate, 0, 0, 0, 36524), 0, none);
      add_row(make_req(CmdToDate, 0, 0, 0, 36525), 0, none);
      add_row(make_req(CmdToDate, 16383, 15, 31, 1461), 0, none);

      // hold reset, then release on a falling edge
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].rsp);
         if (i == directed_rows.size() - 1) drain_pipeline();
         else pace_sender();
      end

      for (uint_type i = 0; i < RandomItems; i++) begin
         send_item(draw_item(), 1'b0, none);
         if (i == RandomItems / 2 || i == RandomItems - 1) drain_pipeline();
         else pace_sender();
      end

      // let any stray transaction show up
      repeat (PipeDepth + 10) @(negedge clock);
      if (mismatches == 0 && outstanding_rsps.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- gregorian_date_daycount_converter_unit.f -----
sv/gdc_pkg.sv
sv/gregorian_date_daycount_converter_unit.sv
tb/tb.sv
